### sv/dna_multi_pattern_counter_unit_defines.svh
// ----------------------------------------------------------------------------
// DNA multi-pattern counter: assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef DNA_MULTI_PATTERN_COUNTER_UNIT_DEFINES_SVH
`define DNA_MULTI_PATTERN_COUNTER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DMPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DMPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/dmpc_pkg.sv
// ----------------------------------------------------------------------------
// DNA multi-pattern counter: package
// Sizes, request codes, register indexes and channel payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package dmpc_pkg;

  // Block sizes.
  localparam int NUM_PATTERNS = 16;
  localparam int MAX_LEN      = 6;
  localparam int COUNT_BITS   = 32;

  // Derived widths.
  localparam int WIN_W   = 2 * MAX_LEN;
  localparam int SEEN_W  = $clog2(MAX_LEN + 1);
  localparam int SLOT_W  = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;

  // Fixed field widths of the channels.
  localparam int TYPE_W  = 2;
  localparam int IDX_W   = 4;
  localparam int BASES_W = 12;
  localparam int LEN_W   = 3;
  localparam int BASE_W  = 2;
  localparam int CNTV_W  = 32;
  localparam int MASK_W  = 16;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int PIU_W      = 5;
  localparam logic [0:0] REG_PATTERNS_IN_USE = 1'b0;
  localparam logic [PIU_W-1:0] PIU_RESET = PIU_W'(1);

  // Request kinds.
  typedef enum logic [TYPE_W-1:0] {
    REQ_LOAD  = 2'd0,
    REQ_TEXT  = 2'd1,
    REQ_READ  = 2'd2,
    REQ_START = 2'd3
  } req_type_e;

  // Request payload.
  typedef struct packed {
    req_type_e            req_type;
    logic [IDX_W-1:0]     pattern_index;
    logic [BASES_W-1:0]   pattern_bases;
    logic [LEN_W-1:0]     pattern_length;
    logic [BASE_W-1:0]    text_base;
  } req_t;

  // Result payload.
  typedef struct packed {
    logic [CNTV_W-1:0] count_value;
    logic [MASK_W-1:0] match_mask;
  } rsp_t;

endpackage

`default_nettype wire

### sv/dmpc_req_if.sv
// ----------------------------------------------------------------------------
// DNA multi-pattern counter: request channel
// Valid/ready channel that carries one request per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface dmpc_req_if;
  logic          valid;
  logic          ready;
  dmpc_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### sv/dmpc_rsp_if.sv
// ----------------------------------------------------------------------------
// DNA multi-pattern counter: result channel
// Valid/ready channel that carries one result per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface dmpc_rsp_if;
  logic          valid;
  logic          ready;
  dmpc_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### sv/dna_multi_pattern_counter_unit.sv
// ----------------------------------------------------------------------------
// DNA multi-pattern counter
// Counts overlapping occurrences of short DNA patterns in a base stream.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Handshake        Payload
// req_i    in         valid/ready      req_type, pattern_index, pattern_bases,
//                                      pattern_length, text_base
// rsp_o    out        valid/ready      count_value, match_mask
// APB      in/out     psel/penable     patterns_in_use at byte address 0
//
// One request per cycle is sustained while rsp_o is ready; a request passes
// the input register, then the result register, which presents its result.
// The rate is set by the per-slot comparators and count incrementers,
// which all work in parallel.
// Reset clears counts, the base window, bases seen and both valid flags;
// pattern and length slots are undefined until loaded.
// A stalled result holds the input register; ready falls only once both
// registers are full.
`default_nettype none

`include "dna_multi_pattern_counter_unit_defines.svh"

module dna_multi_pattern_counter_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  dmpc_req_if.sink                           req_i,
  dmpc_rsp_if.source                         rsp_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [dmpc_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [dmpc_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [dmpc_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready
);

  // Matching of one slot against the newest bases of the window.
  function automatic logic slot_hit(
    input logic [dmpc_pkg::WIN_W-1:0]  pat,
    input logic [dmpc_pkg::LEN_W-1:0]  len,
    input logic [dmpc_pkg::WIN_W-1:0]  win,
    input logic [dmpc_pkg::SEEN_W-1:0] seen
  );
    logic hit;
    logic eq;
    hit = 1'b0;
    for (int l = 1; l <= dmpc_pkg::MAX_LEN; l++) begin
      eq = 1'b1;
      for (int j = 0; j < l; j++) begin
        if (pat[2*j +: 2] != win[2*(l-1-j) +: 2]) eq = 1'b0;
      end
      if ((int'(len) == l) && (int'(seen) >= l) && eq) hit = 1'b1;
    end
    return hit;
  endfunction

  // Configuration register.
  logic [dmpc_pkg::PIU_W-1:0] piu_q;
  logic                       cfg_wr;
  logic                       cfg_sel;

  // Input stage.
  logic           v1_q;
  dmpc_pkg::req_t item_q;
  logic           adv;

  // Block state.
  logic [dmpc_pkg::WIN_W-1:0]      pat_q [dmpc_pkg::NUM_PATTERNS];
  logic [dmpc_pkg::WIN_W-1:0]      pat_d [dmpc_pkg::NUM_PATTERNS];
  logic [dmpc_pkg::LEN_W-1:0]      len_q [dmpc_pkg::NUM_PATTERNS];
  logic [dmpc_pkg::LEN_W-1:0]      len_d [dmpc_pkg::NUM_PATTERNS];
  logic [dmpc_pkg::COUNT_BITS-1:0] cnt_q [dmpc_pkg::NUM_PATTERNS];
  logic [dmpc_pkg::COUNT_BITS-1:0] cnt_d [dmpc_pkg::NUM_PATTERNS];
  logic [dmpc_pkg::WIN_W-1:0]      window_q, window_d;
  logic [dmpc_pkg::SEEN_W-1:0]     seen_q, seen_d;

  // Processing terms.
  logic [dmpc_pkg::WIN_W-1:0]      win_shift;
  logic [dmpc_pkg::SEEN_W-1:0]     seen_inc;
  logic [dmpc_pkg::NUM_PATTERNS-1:0] hit;
  logic [dmpc_pkg::SLOT_W-1:0]     slot;
  logic                            slot_ok;

  // Result stage.
  logic           out_vld_q;
  dmpc_pkg::rsp_t rsp_q, rsp_d;

  // The configuration port writes in the access phase and never waits.
  assign pready  = 1'b1;
  assign cfg_sel = (paddr[dmpc_pkg::CFG_ADDR_W-1:2] == dmpc_pkg::REG_PATTERNS_IN_USE);
  assign cfg_wr  = psel && penable && pwrite && cfg_sel;
  assign prdata  = cfg_sel ? dmpc_pkg::CFG_DATA_W'(piu_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      piu_q <= dmpc_pkg::PIU_RESET;
    end else if (cfg_wr) begin
      piu_q <= pwdata[dmpc_pkg::PIU_W-1:0];
    end
  end

  // The input register moves on when it is empty or its request is processed.
  assign adv         = v1_q && (!out_vld_q || rsp_o.ready);
  assign req_i.ready = !v1_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (req_i.ready) begin
      v1_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      item_q <= req_i.data;
    end
  end

  // The window as it stands after a text base, and the slot comparators.
  assign win_shift = dmpc_pkg::WIN_W'({window_q, item_q.text_base});
  assign seen_inc  = (int'(seen_q) < dmpc_pkg::MAX_LEN) ? seen_q + 1'b1 : seen_q;
  assign slot      = item_q.pattern_index[dmpc_pkg::SLOT_W-1:0];
  assign slot_ok   = int'(item_q.pattern_index) < dmpc_pkg::NUM_PATTERNS;

  always_comb begin
    for (int k = 0; k < dmpc_pkg::NUM_PATTERNS; k++) begin
      hit[k] = (int'(piu_q) > k) && slot_hit(pat_q[k], len_q[k], win_shift, seen_inc);
    end
  end

  // Next state and result for the request in the input register.
  always_comb begin
    pat_d    = pat_q;
    len_d    = len_q;
    cnt_d    = cnt_q;
    window_d = window_q;
    seen_d   = seen_q;
    rsp_d    = '0;
    if (adv) begin
      unique case (item_q.req_type)
        dmpc_pkg::REQ_LOAD: begin
          if (slot_ok) begin
            pat_d[slot] = dmpc_pkg::WIN_W'(item_q.pattern_bases);
            len_d[slot] = item_q.pattern_length;
            cnt_d[slot] = '0;
          end
        end
        dmpc_pkg::REQ_TEXT: begin
          window_d = win_shift;
          seen_d   = seen_inc;
          for (int k = 0; k < dmpc_pkg::NUM_PATTERNS; k++) begin
            if (hit[k] && (cnt_q[k] != '1)) cnt_d[k] = cnt_q[k] + 1'b1;
          end
          rsp_d.match_mask = dmpc_pkg::MASK_W'(hit);
        end
        dmpc_pkg::REQ_READ: begin
          if (slot_ok) rsp_d.count_value = dmpc_pkg::CNTV_W'(cnt_q[slot]);
        end
        dmpc_pkg::REQ_START: begin
          window_d = '0;
          seen_d   = '0;
          for (int k = 0; k < dmpc_pkg::NUM_PATTERNS; k++) begin
            cnt_d[k] = '0;
          end
        end
        default: begin
          rsp_d = '0;
        end
      endcase
    end
  end

  // State with a defined reset value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
      seen_q   <= '0;
      for (int k = 0; k < dmpc_pkg::NUM_PATTERNS; k++) begin
        cnt_q[k] <= '0;
      end
    end else begin
      window_q <= window_d;
      seen_q   <= seen_d;
      cnt_q    <= cnt_d;
    end
  end

  // Pattern and length slots hold whatever is loaded.
  always_ff @(posedge clk_i) begin
    pat_q <= pat_d;
    len_q <= len_d;
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid = out_vld_q;
  assign rsp_o.data  = rsp_q;

  // Checks on the internal pipeline and state.
  `DMPC_ASSERT_NOW(a_mask_excl_count, out_vld_q && (rsp_q.match_mask != '0),
    rsp_q.count_value == '0, "result carries both a match mask and a count")
  `DMPC_ASSERT_NOW(a_stall_full, !req_i.ready,
    v1_q && out_vld_q && !rsp_o.ready, "request refused while a stage is free")
  `DMPC_ASSERT_NEXT(a_adv_result, adv, out_vld_q,
    "processed request left no result")
  `DMPC_ASSERT_NEXT(a_start_clears, adv && (item_q.req_type == dmpc_pkg::REQ_START),
    (window_q == '0) && (seen_q == '0), "start request did not clear the window")

endmodule

`default_nettype wire
